// File: sv/wcmp_pkg.sv
// Shared constants, codes, state types and index helpers for the walk count
// matrix power block. Depends on nothing; used by walk_count_matrix_power_top.
package wcmp_pkg;

    localparam int DIM       = 10;
    localparam int NE        = DIM * DIM;
    localparam int AW        = $clog2(NE);
    localparam int IW        = 4;
    localparam int VW        = 30;
    localparam int QW        = 63;
    localparam int SER_STEPS = VW;
    localparam int CNTW      = $clog2(SER_STEPS);

    localparam logic [VW-1:0] MOD_RESET = 30'd1000000007;

    localparam logic [1:0] MODE_MAT   = 2'd0;
    localparam logic [1:0] MODE_VEC   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_LD   = 6'b000100,
        ST_RUN  = 6'b001000,
        ST_CHK  = 6'b010000,
        ST_SUM  = 6'b100000
    } state_t;

    typedef enum logic [5:0] {
        PH_WR_M  = 6'b000001,
        PH_WR_V  = 6'b000010,
        PH_MAT   = 6'b000100,
        PH_VEC   = 6'b001000,
        PH_APPLY = 6'b010000,
        PH_SQ    = 6'b100000
    } phase_t;

    function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(int'(r) * DIM + int'(c));
    endfunction

    // Reset pattern of the transition matrix: ones where row and column differ by at most two.
    function automatic logic band(input logic [IW-1:0] r, input logic [IW-1:0] c);
        int d;
        d = int'(r) - int'(c);
        return (d >= -2) && (d <= 2);
    endfunction

endpackage

// File: sv/walk_count_matrix_power_top.sv
// Walk count matrix power: modular vector times matrix power, summed.
// Depends on wcmp_pkg (constants, codes, state types, index helpers).
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. mode 0 writes transition matrix entry (row_index, col_index),
//   mode 1 writes start vector entry col_index; both reduce entry_value
//   modulo the modulus and give no result. Out-of-range indexes and mode 3
//   are dropped at once. mode 2 is a query with exponent step_count.
//   Result channel: done pulses for one cycle with walk_total; the receiver
//   cannot stall, so every result must be taken in that cycle.
//   Config: cfg_we writes cfg_wdata into the modulus (0 acts as 1); write it
//   only while busy is low.
// Datapath:
//   All modular products run on one bit-serial multiply-reduce unit, one
//   operand bit per cycle: a multiply-accumulate is a memory read, an
//   operand load and 30 serial steps, one per operand bit. A write also
//   passes through the unit. A query copies the matrix and start vector in,
//   then per exponent bit runs vector times matrix if the bit is set and a
//   squaring while higher bits remain, and ends with the final sum.
// Reset: modulus, transition matrix (banded) and start vector go to their
//   defaults; the matrix uses per-entry valid bits, so no clearing pass.
module walk_count_matrix_power_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [wcmp_pkg::IW-1:0]        row_index,
    input  logic [wcmp_pkg::IW-1:0]        col_index,
    input  logic [wcmp_pkg::VW-1:0]        entry_value,
    input  logic [wcmp_pkg::QW-1:0]        step_count,
    input  logic                           cfg_we,
    input  logic [wcmp_pkg::VW-1:0]        cfg_wdata,
    output logic                           done,
    output logic [wcmp_pkg::VW-1:0]        walk_total
);

    localparam int DIM  = wcmp_pkg::DIM;
    localparam int NE   = wcmp_pkg::NE;
    localparam int AW   = wcmp_pkg::AW;
    localparam int IW   = wcmp_pkg::IW;
    localparam int VW   = wcmp_pkg::VW;
    localparam int QW   = wcmp_pkg::QW;
    localparam int CNTW = wcmp_pkg::CNTW;
    localparam logic [IW-1:0]   LAST_IDX = IW'(DIM - 1);
    localparam logic [CNTW-1:0] LAST_CNT = CNTW'(wcmp_pkg::SER_STEPS - 1);

    wcmp_pkg::state_t state_reg, state_next;
    wcmp_pkg::phase_t ph_reg, ph_next;

    logic [IW-1:0]   ci_reg, ci_next, cj_reg, cj_next, ck_reg, ck_next;
    logic [VW-1:0]   acc_reg, acc_next;
    logic [QW-1:0]   q_reg, q_next;
    logic            cur_reg, cur_next;
    logic [VW-1:0]   ser_a_reg, ser_a_next, ser_b_reg, ser_b_next;
    logic [VW-1:0]   ser_r_reg, ser_r_next;
    logic [CNTW-1:0] ser_cnt_reg, ser_cnt_next;
    logic [VW-1:0]   modulus_reg;
    logic            done_reg, done_next;
    logic [VW-1:0]   total_reg, total_next;
    logic [VW-1:0]   result_reg, result_next;

    logic [VW-1:0] sv_reg [DIM];
    logic [VW-1:0] wv_reg [DIM];
    logic [VW-1:0] wt_reg [DIM];
    logic [NE-1:0] tm_vld_reg;

    // Memories: transition matrix, and two power banks used ping-pong.
    logic [VW-1:0] tm_mem [NE];
    logic [VW-1:0] pm_mem [2][NE];
    logic [VW-1:0] rd_a_q, rd_b_q, tm_q;
    logic          tm_vld_q, band_q;

    logic            tm_we, sv_we, wv_we, wv_load_all, wt_we, pm_we, pm_wsel;
    logic [VW-1:0]   pm_wdata;
    logic [AW-1:0]   addr_a, addr_b, addr_t;

    logic [VW-1:0]   m_eff;
    logic [VW-1:0]   ser_add;
    logic [VW+1:0]   ser_t, ser_t1, ser_t2, m_ext;
    logic [VW-1:0]   ser_res;
    logic [VW:0]     mac_s, tot_s;
    logic [VW-1:0]   mac_sum, tot_sum;
    logic            last_step, last_i, last_j, last_k;

    assign busy       = (state_reg != wcmp_pkg::ST_IDLE);
    assign done       = done_reg;
    assign walk_total = result_reg;

    assign m_eff = (modulus_reg == '0) ? VW'(1) : modulus_reg;
    assign m_ext = {2'b00, m_eff};

    // One serial step: r = 2r + bit*a, then fold back below the modulus.
    // With r < m and a < m (or a = 1) the sum stays below 3m.
    assign ser_add = ser_b_reg[VW-1] ? ser_a_reg : '0;
    assign ser_t   = {1'b0, ser_r_reg, 1'b0} + {2'b00, ser_add};
    assign ser_t1  = (ser_t >= m_ext) ? ser_t - m_ext : ser_t;
    assign ser_t2  = (ser_t1 >= m_ext) ? ser_t1 - m_ext : ser_t1;
    assign ser_res = ser_t2[VW-1:0];

    assign mac_s   = {1'b0, acc_reg} + {1'b0, ser_res};
    assign mac_sum = (mac_s >= {1'b0, m_eff}) ? VW'(mac_s - {1'b0, m_eff}) : mac_s[VW-1:0];
    assign tot_s   = {1'b0, total_reg} + {1'b0, wv_reg[cj_reg]};
    assign tot_sum = (tot_s >= {1'b0, m_eff}) ? VW'(tot_s - {1'b0, m_eff}) : tot_s[VW-1:0];

    assign last_step = (ser_cnt_reg == LAST_CNT);
    assign last_i    = (ci_reg == LAST_IDX);
    assign last_j    = (cj_reg == LAST_IDX);
    assign last_k    = (ck_reg == LAST_IDX);

    assign addr_a = wcmp_pkg::mat_addr(ci_reg, ck_reg);
    assign addr_b = wcmp_pkg::mat_addr(ck_reg, cj_reg);
    assign addr_t = wcmp_pkg::mat_addr(ci_reg, cj_reg);

    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        ci_next      = ci_reg;
        cj_next      = cj_reg;
        ck_next      = ck_reg;
        acc_next     = acc_reg;
        q_next       = q_reg;
        cur_next     = cur_reg;
        ser_a_next   = ser_a_reg;
        ser_b_next   = ser_b_reg;
        ser_r_next   = ser_r_reg;
        ser_cnt_next = ser_cnt_reg;
        done_next    = 1'b0;
        total_next   = total_reg;
        result_next  = result_reg;
        tm_we        = 1'b0;
        sv_we        = 1'b0;
        wv_we        = 1'b0;
        wv_load_all  = 1'b0;
        wt_we        = 1'b0;
        pm_we        = 1'b0;
        pm_wsel      = cur_reg;
        pm_wdata     = ser_res;

        case (state_reg)
            wcmp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ci_next      = row_index;
                    cj_next      = col_index;
                    ck_next      = '0;
                    ser_a_next   = VW'(1);
                    ser_b_next   = entry_value;
                    ser_r_next   = '0;
                    ser_cnt_next = '0;
                    case (mode)
                        wcmp_pkg::MODE_MAT:
                        begin
                            if ({1'b0, row_index} < (IW+1)'(DIM)
                                && {1'b0, col_index} < (IW+1)'(DIM))
                            begin
                                ph_next    = wcmp_pkg::PH_WR_M;
                                state_next = wcmp_pkg::ST_RUN;
                            end
                        end
                        wcmp_pkg::MODE_VEC:
                        begin
                            if ({1'b0, col_index} < (IW+1)'(DIM))
                            begin
                                ph_next    = wcmp_pkg::PH_WR_V;
                                state_next = wcmp_pkg::ST_RUN;
                            end
                        end
                        wcmp_pkg::MODE_QUERY:
                        begin
                            ci_next    = '0;
                            cj_next    = '0;
                            q_next     = step_count;
                            ph_next    = wcmp_pkg::PH_MAT;
                            state_next = wcmp_pkg::ST_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            wcmp_pkg::ST_RD:
            begin
                state_next = wcmp_pkg::ST_LD;
            end

            wcmp_pkg::ST_LD:
            begin
                ser_r_next   = '0;
                ser_cnt_next = '0;
                state_next   = wcmp_pkg::ST_RUN;
                case (ph_reg)
                    wcmp_pkg::PH_MAT:
                    begin
                        ser_a_next = VW'(1);
                        ser_b_next = tm_vld_q ? tm_q : VW'(band_q);
                    end
                    wcmp_pkg::PH_VEC:
                    begin
                        ser_a_next = VW'(1);
                        ser_b_next = sv_reg[cj_reg];
                    end
                    wcmp_pkg::PH_APPLY:
                    begin
                        ser_a_next = wv_reg[ck_reg];
                        ser_b_next = rd_b_q;
                    end
                    wcmp_pkg::PH_SQ:
                    begin
                        ser_a_next = rd_a_q;
                        ser_b_next = rd_b_q;
                    end
                    default:
                    begin
                    end
                endcase
            end

            wcmp_pkg::ST_RUN:
            begin
                ser_r_next   = ser_res;
                ser_b_next   = {ser_b_reg[VW-2:0], 1'b0};
                ser_cnt_next = ser_cnt_reg + CNTW'(1);
                if (last_step)
                begin
                    ser_cnt_next = '0;
                    case (ph_reg)
                        wcmp_pkg::PH_WR_M:
                        begin
                            tm_we      = 1'b1;
                            state_next = wcmp_pkg::ST_IDLE;
                        end
                        wcmp_pkg::PH_WR_V:
                        begin
                            sv_we      = 1'b1;
                            state_next = wcmp_pkg::ST_IDLE;
                        end
                        wcmp_pkg::PH_MAT:
                        begin
                            pm_we      = 1'b1;
                            state_next = wcmp_pkg::ST_RD;
                            if (last_j)
                            begin
                                cj_next = '0;
                                if (last_i)
                                begin
                                    ci_next    = '0;
                                    ph_next    = wcmp_pkg::PH_VEC;
                                    state_next = wcmp_pkg::ST_LD;
                                end
                                else
                                begin
                                    ci_next = ci_reg + IW'(1);
                                end
                            end
                            else
                            begin
                                cj_next = cj_reg + IW'(1);
                            end
                        end
                        wcmp_pkg::PH_VEC:
                        begin
                            wv_we = 1'b1;
                            if (last_j)
                            begin
                                cj_next    = '0;
                                state_next = wcmp_pkg::ST_CHK;
                            end
                            else
                            begin
                                cj_next    = cj_reg + IW'(1);
                                state_next = wcmp_pkg::ST_LD;
                            end
                        end
                        wcmp_pkg::PH_APPLY:
                        begin
                            state_next = wcmp_pkg::ST_RD;
                            if (last_k)
                            begin
                                ck_next  = '0;
                                acc_next = '0;
                                wt_we    = 1'b1;
                                if (last_j)
                                begin
                                    wv_load_all = 1'b1;
                                    cj_next     = '0;
                                    q_next      = q_reg >> 1;
                                    if (q_reg[QW-1:1] != '0)
                                    begin
                                        ci_next = '0;
                                        ph_next = wcmp_pkg::PH_SQ;
                                    end
                                    else
                                    begin
                                        total_next = '0;
                                        state_next = wcmp_pkg::ST_SUM;
                                    end
                                end
                                else
                                begin
                                    cj_next = cj_reg + IW'(1);
                                end
                            end
                            else
                            begin
                                acc_next = mac_sum;
                                ck_next  = ck_reg + IW'(1);
                            end
                        end
                        wcmp_pkg::PH_SQ:
                        begin
                            state_next = wcmp_pkg::ST_RD;
                            if (last_k)
                            begin
                                ck_next  = '0;
                                acc_next = '0;
                                pm_we    = 1'b1;
                                pm_wsel  = ~cur_reg;
                                pm_wdata = mac_sum;
                                if (last_j)
                                begin
                                    cj_next = '0;
                                    if (last_i)
                                    begin
                                        ci_next    = '0;
                                        cur_next   = ~cur_reg;
                                        state_next = wcmp_pkg::ST_CHK;
                                    end
                                    else
                                    begin
                                        ci_next = ci_reg + IW'(1);
                                    end
                                end
                                else
                                begin
                                    cj_next = cj_reg + IW'(1);
                                end
                            end
                            else
                            begin
                                acc_next = mac_sum;
                                ck_next  = ck_reg + IW'(1);
                            end
                        end
                        default:
                        begin
                            state_next = wcmp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Walk the exponent one bit at a time, low bit first.
            wcmp_pkg::ST_CHK:
            begin
                ci_next  = '0;
                cj_next  = '0;
                ck_next  = '0;
                acc_next = '0;
                if (q_reg == '0)
                begin
                    total_next = '0;
                    state_next = wcmp_pkg::ST_SUM;
                end
                else if (q_reg[0])
                begin
                    ph_next    = wcmp_pkg::PH_APPLY;
                    state_next = wcmp_pkg::ST_RD;
                end
                else
                begin
                    q_next     = q_reg >> 1;
                    ph_next    = wcmp_pkg::PH_SQ;
                    state_next = wcmp_pkg::ST_RD;
                end
            end

            wcmp_pkg::ST_SUM:
            begin
                total_next = tot_sum;
                if (last_j)
                begin
                    cj_next     = '0;
                    done_next   = 1'b1;
                    result_next = tot_sum;
                    state_next  = wcmp_pkg::ST_IDLE;
                end
                else
                begin
                    cj_next = cj_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = wcmp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and vector registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wcmp_pkg::ST_IDLE;
            ph_reg      <= wcmp_pkg::PH_MAT;
            ci_reg      <= '0;
            cj_reg      <= '0;
            ck_reg      <= '0;
            acc_reg     <= '0;
            cur_reg     <= 1'b0;
            ser_cnt_reg <= '0;
            done_reg    <= 1'b0;
            modulus_reg <= wcmp_pkg::MOD_RESET;
            tm_vld_reg  <= '0;
            for (int x = 0; x < DIM; x++)
            begin
                sv_reg[x] <= (x == 0) ? '0 : VW'(1);
            end
        end
        else
        begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            ci_reg      <= ci_next;
            cj_reg      <= cj_next;
            ck_reg      <= ck_next;
            acc_reg     <= acc_next;
            cur_reg     <= cur_next;
            ser_cnt_reg <= ser_cnt_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            if (tm_we)
            begin
                tm_vld_reg[addr_t] <= 1'b1;
            end
            if (sv_we)
            begin
                sv_reg[cj_reg] <= ser_res;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        ser_a_reg  <= ser_a_next;
        ser_b_reg  <= ser_b_next;
        ser_r_reg  <= ser_r_next;
        total_reg  <= total_next;
        result_reg <= result_next;
        if (wv_we)
        begin
            wv_reg[cj_reg] <= ser_res;
        end
        if (wt_we)
        begin
            wt_reg[cj_reg] <= mac_sum;
        end
        if (wv_load_all)
        begin
            for (int x = 0; x < DIM - 1; x++)
            begin
                wv_reg[x] <= wt_reg[x];
            end
            wv_reg[DIM-1] <= mac_sum;
        end
    end

    // Synchronous memories: one write port, registered reads.
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            tm_mem[addr_t] <= ser_res;
        end
        tm_q     <= tm_mem[addr_t];
        tm_vld_q <= tm_vld_reg[addr_t];
        band_q   <= wcmp_pkg::band(ci_reg, cj_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pm_mem[pm_wsel][addr_t] <= pm_wdata;
        end
        rd_a_q <= pm_mem[cur_reg][addr_a];
        rd_b_q <= pm_mem[cur_reg][addr_b];
    end

    // A result only leaves the final summation pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == wcmp_pkg::ST_SUM))
        else $error("result strobe without a summation pass");

    // Leaving idle requires a taken command.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("block went busy without a command");

    // The serial step counter only moves while the unit runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ser_cnt_reg != '0) |-> (state_reg == wcmp_pkg::ST_RUN))
        else $error("serial counter active outside run state");

    // Squaring never overwrites the bank it is reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pm_we && ph_reg == wcmp_pkg::PH_SQ) |-> (pm_wsel != cur_reg))
        else $error("squaring writes into its source bank");

endmodule

// File: tb/walk_total_checker.sv
// Checker for walk_count_matrix_power_top: mirrors the matrix, vector and modulus,
// predicts walk_total for each accepted query and compares it with every done pulse.
// Depends on wcmp_pkg for the mode codes and field widths.
`timescale 1ns / 1ps

module walk_total_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              mode,
    input  logic [wcmp_pkg::IW-1:0] row_index,
    input  logic [wcmp_pkg::IW-1:0] col_index,
    input  logic [wcmp_pkg::VW-1:0] entry_value,
    input  logic [wcmp_pkg::QW-1:0] step_count,
    input  logic                    cfg_we,
    input  logic [wcmp_pkg::VW-1:0] cfg_wdata,
    input  logic                    done,
    input  logic [wcmp_pkg::VW-1:0] walk_total,
    output int                      fail_count,
    output int                      pending
);
    localparam int DIM = wcmp_pkg::DIM;
    localparam int NE  = wcmp_pkg::NE;
    localparam int VW  = wcmp_pkg::VW;
    localparam int QW  = wcmp_pkg::QW;

    logic [63:0]   trans_mirror [0:NE-1];
    logic [63:0]   start_mirror [0:DIM-1];
    logic [63:0]   modulus_mirror;
    logic [VW-1:0] expected_totals [$];

    assign pending = expected_totals.size();

    function automatic logic [63:0] eff_modulus();
        return (modulus_mirror == 0) ? 64'd1 : modulus_mirror;
    endfunction

    // Square-and-multiply of the start row through the transition matrix.
    function automatic logic [VW-1:0] predict_walk_total(input logic [QW-1:0] steps);
        logic [63:0] m;
        logic [63:0] pw [0:NE-1];
        logic [63:0] sq [0:NE-1];
        logic [63:0] wv [0:DIM-1];
        logic [63:0] tmp [0:DIM-1];
        logic [63:0] acc;
        logic [QW-1:0] q;
        m = eff_modulus();
        q = steps;
        for (int i = 0; i < DIM; i++) wv[i] = start_mirror[i] % m;
        for (int i = 0; i < NE; i++) pw[i] = trans_mirror[i] % m;
        while (q != 0)
        begin
            if (q[0])
            begin
                for (int j = 0; j < DIM; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < DIM; k++)
                        acc = (acc + wv[k] * pw[k*DIM+j]) % m;
                    tmp[j] = acc;
                end
                for (int j = 0; j < DIM; j++) wv[j] = tmp[j];
            end
            q = q >> 1;
            if (q != 0)
            begin
                for (int i = 0; i < DIM; i++)
                    for (int j = 0; j < DIM; j++)
                    begin
                        acc = 0;
                        for (int k = 0; k < DIM; k++)
                            acc = (acc + pw[i*DIM+k] * pw[k*DIM+j]) % m;
                        sq[i*DIM+j] = acc;
                    end
                for (int i = 0; i < NE; i++) pw[i] = sq[i];
            end
        end
        acc = 0;
        for (int i = 0; i < DIM; i++) acc = (acc + wv[i]) % m;
        return acc[VW-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [VW-1:0] want,
                                   input logic [VW-1:0] got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_mirror = {34'd0, wcmp_pkg::MOD_RESET};
            for (int i = 0; i < DIM; i++)
            begin
                start_mirror[i] = (i == 0) ? 64'd0 : 64'd1;
                for (int j = 0; j < DIM; j++)
                    trans_mirror[i*DIM+j] = ((i - j) >= -2 && (i - j) <= 2) ? 64'd1 : 64'd0;
            end
            expected_totals.delete();
            fail_count = 0;
        end
        else
        begin
            // Retire results before taking a new item in the same cycle.
            if (done)
            begin
                if (expected_totals.size() == 0)
                    report_mismatch("unexpected walk_total", '0, walk_total);
                else if (expected_totals[0] !== walk_total)
                    report_mismatch("walk_total", expected_totals.pop_front(), walk_total);
                else
                    void'(expected_totals.pop_front());
            end
            if (cfg_we)
                modulus_mirror = {34'd0, cfg_wdata};
            if (start && !busy)
            begin
                if (mode == wcmp_pkg::MODE_MAT && row_index < DIM && col_index < DIM)
                    trans_mirror[row_index*DIM+col_index] = entry_value % eff_modulus();
                else if (mode == wcmp_pkg::MODE_VEC && col_index < DIM)
                    start_mirror[col_index] = entry_value % eff_modulus();
                else if (mode == wcmp_pkg::MODE_QUERY)
                    expected_totals.push_back(predict_walk_total(step_count));
            end
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the walk_count_matrix_power_top testbench: clock, reset, command and
// modulus stimulus, verdict. Depends on wcmp_pkg, the block and walk_total_checker.
`timescale 1ns / 1ps

module testbench;
    localparam int         IW          = wcmp_pkg::IW;
    localparam int         VW          = wcmp_pkg::VW;
    localparam int         QW          = wcmp_pkg::QW;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 20_000_000;
    localparam int         DRAIN_WAIT  = 64;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [1:0]    mode = wcmp_pkg::MODE_MAT;
    logic [IW-1:0] row_index = '0;
    logic [IW-1:0] col_index = '0;
    logic [VW-1:0] entry_value = '0;
    logic [QW-1:0] step_count = '0;
    logic          cfg_we = 1'b0;
    logic [VW-1:0] cfg_wdata = '0;
    logic          done;
    logic [VW-1:0] walk_total;
    int            fail_count;
    int            pending;
    int            cycle_count = 0;
    bit            no_idle = 1'b0;

    always #2 clk = ~clk;

    walk_count_matrix_power_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .row_index(row_index), .col_index(col_index), .entry_value(entry_value),
        .step_count(step_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .walk_total(walk_total)
    );

    walk_total_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .row_index(row_index), .col_index(col_index), .entry_value(entry_value),
        .step_count(step_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .walk_total(walk_total), .fail_count(fail_count),
        .pending(pending)
    );

    // Watchdog: stops the run with a failure once cycle_count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one item; hold start until the block takes it.
    task automatic send_item(input logic [1:0] m, input logic [IW-1:0] r,
                             input logic [IW-1:0] c, input logic [VW-1:0] v,
                             input logic [QW-1:0] q);
        int gap;
        if (!no_idle && $urandom_range(99) < 37)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode <= m;
        row_index <= r;
        col_index <= c;
        entry_value <= v;
        step_count <= q;
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    // Drain every pending result, let a trailing write settle, then load the modulus.
    task automatic set_modulus(input logic [VW-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed writes and cheap queries; a little noise.
    task automatic send_random_item();
        int pick;
        logic [QW-1:0] q;
        pick = $urandom_range(99);
        q = QW'({$urandom, $urandom});
        if (pick < 35)
            send_item(wcmp_pkg::MODE_MAT, IW'($urandom_range(9)), IW'($urandom_range(9)),
                      ($urandom_range(1) != 0) ? VW'($urandom) : VW'($urandom_range(5)), q);
        else if (pick < 55)
            send_item(wcmp_pkg::MODE_VEC, IW'($urandom), IW'($urandom_range(9)),
                      ($urandom_range(1) != 0) ? VW'($urandom) : VW'($urandom_range(5)), q);
        else if (pick < 85)
        begin
            // Keep exponents short, since every squaring multiplies the whole matrix.
            pick = $urandom_range(99);
            if (pick < 70)      q = QW'($urandom_range(1));
            else if (pick < 95) q = QW'($urandom_range(2, 3));
            else                q = QW'($urandom_range(4, 7));
            send_item(wcmp_pkg::MODE_QUERY, IW'($urandom), IW'($urandom), VW'($urandom), q);
        end
        else if (pick < 90)
            send_item(MODE_UNUSED, IW'($urandom), IW'($urandom), VW'($urandom), q);
        else
            send_item(2'($urandom_range(1)), IW'($urandom_range(10, 15)), IW'($urandom),
                      VW'($urandom), q);
    endtask

    initial
    begin
        logic [VW-1:0] moduli [0:4];
        moduli = '{30'h3FFF_FFFF, 30'd2, 30'd0, 30'd1, 30'd97};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, extremes, ignored items, one full-width exponent.
        send_item(wcmp_pkg::MODE_QUERY, 4'd0, 4'd0, 30'd0, 63'd0);
        send_item(wcmp_pkg::MODE_QUERY, 4'd0, 4'd0, 30'd0, 63'd1);
        send_item(wcmp_pkg::MODE_QUERY, 4'd0, 4'd0, 30'd0, 63'd2);
        send_item(wcmp_pkg::MODE_MAT, 4'd0, 4'd0, 30'h3FFF_FFFF, 63'd0);
        send_item(wcmp_pkg::MODE_MAT, 4'd9, 4'd9, 30'h3FFF_FFFF, 63'd0);
        send_item(wcmp_pkg::MODE_VEC, 4'd15, 4'd9, 30'h3FFF_FFFF, 63'd0);
        send_item(wcmp_pkg::MODE_VEC, 4'd0, 4'd0, 30'd0, 63'd0);
        send_item(wcmp_pkg::MODE_MAT, 4'd10, 4'd3, 30'd5, 63'd0);
        send_item(wcmp_pkg::MODE_MAT, 4'd3, 4'd15, 30'd5, 63'd0);
        send_item(wcmp_pkg::MODE_VEC, 4'd0, 4'd12, 30'd5, 63'd0);
        send_item(MODE_UNUSED, 4'd4, 4'd4, 30'd7, 63'd3);
        send_item(wcmp_pkg::MODE_QUERY, 4'd0, 4'd0, 30'd0, 63'd3);
        send_item(wcmp_pkg::MODE_QUERY, 4'd15, 4'd15, 30'h3FFF_FFFF, {QW{1'b1}});
        send_item(wcmp_pkg::MODE_QUERY, 4'd0, 4'd0, 30'd0, 63'd0);

        // Each phase reruns random traffic under a new modulus; stored
        // entries keep their old values across the change.
        for (int p = 0; p < 5; p++)
        begin
            set_modulus(moduli[p]);
            for (int n = 0; n < 16; n++)
            begin
                no_idle = (p == 1);
                send_random_item();
            end
        end
        no_idle = 1'b0;
        set_modulus(wcmp_pkg::MOD_RESET);
        for (int n = 0; n < 6; n++)
            send_random_item();
        send_item(wcmp_pkg::MODE_QUERY, 4'd0, 4'd0, 30'd0, 63'd5);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
